// ----- src/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while in reset
`define ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/rsasv_pkg.sv -----
`default_nettype none

package rsasv_pkg;

    localparam int FIELD_W    = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 4;

    localparam logic [1:0] REG_MODULUS  = 2'd0;
    localparam logic [1:0] REG_PRIV_EXP = 2'd1;
    localparam logic [1:0] REG_PUB_EXP  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_SQUARE,
        ST_MULT,
        ST_WRITE
    } rsasv_state_t;

endpackage

`default_nettype wire

// ----- src/rsa_sign_and_verify.sv -----
// channel   | handshake                         | payload
// ----------+-----------------------------------+-------------------------------------------
// input     | s_valid / s_ready                 | s_message_hash
// result    | m_valid / m_ready                 | m_signature, m_recovered, m_matches_res
// config    | psel, penable, pwrite, pready = 1 | paddr, pwdata, prdata
//
// every reduce, square and multiply step of an item goes through the single
// modular double-and-add unit, one bit per cycle
// a modulus below two skips the arithmetic and goes straight to the write state
// aresetn is synchronous and active low; it restores the reset key registers
// s_ready is high only while idle; a finished item waits in its own state when
// the output register is still full, so m_ready low stalls the whole block
`default_nettype none

module rsa_sign_and_verify
    import rsasv_pkg::*;
#(
    parameter int KEY_BITS = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,

    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [FIELD_W-1:0]    s_message_hash,

    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic      [FIELD_W-1:0]    m_signature,
    output logic      [FIELD_W-1:0]    m_recovered,
    output logic                       m_matches_res
);

`include "assert_macros.svh"

    localparam int CNT_W = $clog2(KEY_BITS);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(KEY_BITS - 1);
    localparam logic [KEY_BITS-1:0] KEY_ONE = {{(KEY_BITS-1){1'b0}}, 1'b1};
    localparam logic [KEY_BITS-1:0] KEY_TWO = {{(KEY_BITS-2){1'b0}}, 2'b10};

    // configuration
    logic [CFG_DATA_W-1:0] modulus_reg, modulus_next;
    logic [CFG_DATA_W-1:0] priv_exp_reg, priv_exp_next;
    logic [CFG_DATA_W-1:0] pub_exp_reg, pub_exp_next;

    // control
    rsasv_state_t     state_reg, state_next;
    logic [CNT_W-1:0] step_cnt_reg, step_cnt_next;
    logic [CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic             verify_reg, verify_next;
    logic             m_valid_reg, m_valid_next;

    // datapath
    logic [KEY_BITS-1:0] rem_reg, rem_next;
    logic [KEY_BITS-1:0] h_reg, h_next;
    logic [KEY_BITS-1:0] base_reg, base_next;
    logic [KEY_BITS-1:0] exp_reg, exp_next;
    logic [KEY_BITS-1:0] pacc_reg, pacc_next;
    logic [KEY_BITS-1:0] macc_reg, macc_next;
    logic [KEY_BITS-1:0] mop_reg, mop_next;
    logic [KEY_BITS-1:0] sig_reg, sig_next;
    logic [KEY_BITS-1:0] rec_reg, rec_next;
    logic [FIELD_W-1:0]  m_signature_reg, m_signature_next;
    logic [FIELD_W-1:0]  m_recovered_reg, m_recovered_next;
    logic                m_matches_res_reg, m_matches_res_next;

    // masked key values
    logic [63:0]         modulus_wide, priv_exp_wide, pub_exp_wide, hash_wide;
    logic [KEY_BITS-1:0] n_k, d_k, e_k, h_k;
    logic [63:0]         sig_wide, rec_wide;

    // shared unit: (2x + y) mod n for x, y < n
    logic [KEY_BITS-1:0] unit_x, unit_y, unit_res;
    logic [KEY_BITS+1:0] unit_t, unit_n1, unit_n2;

    logic cfg_wr, accept, out_free, small_n;
    logic mul_last, pow_last, sq_done, take_mult, bit_done, pow_done;

    assign modulus_wide  = {32'd0, modulus_reg};
    assign priv_exp_wide = {32'd0, priv_exp_reg};
    assign pub_exp_wide  = {32'd0, pub_exp_reg};
    assign hash_wide     = {32'd0, s_message_hash};
    assign n_k           = modulus_wide[KEY_BITS-1:0];
    assign d_k           = priv_exp_wide[KEY_BITS-1:0];
    assign e_k           = pub_exp_wide[KEY_BITS-1:0];
    assign h_k           = hash_wide[KEY_BITS-1:0];
    assign sig_wide      = 64'(sig_reg);
    assign rec_wide      = 64'(rec_reg);
    assign small_n       = (n_k < KEY_TWO);

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        modulus_next  = modulus_reg;
        priv_exp_next = priv_exp_reg;
        pub_exp_next  = pub_exp_reg;
        if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_MODULUS:  modulus_next  = pwdata;
                REG_PRIV_EXP: priv_exp_next = pwdata;
                REG_PUB_EXP:  pub_exp_next  = pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_MODULUS:  prdata = modulus_reg;
            REG_PRIV_EXP: prdata = priv_exp_reg;
            REG_PUB_EXP:  prdata = pub_exp_reg;
            default:      prdata = '0;
        endcase
    end

    // shared modular double-and-add unit
    always_comb begin
        if (state_reg == ST_REDUCE) begin
            unit_x = rem_reg;
            unit_y = {{(KEY_BITS-1){1'b0}}, h_reg[KEY_BITS-1]};
        end else begin
            unit_x = macc_reg;
            unit_y = mop_reg[KEY_BITS-1] ? pacc_reg : '0;
        end
        unit_t  = {1'b0, unit_x, 1'b0} + {2'b00, unit_y};
        unit_n1 = {2'b00, n_k};
        unit_n2 = {1'b0, n_k, 1'b0};
        priority if (unit_t >= unit_n2) begin
            unit_res = unit_t[KEY_BITS-1:0] - unit_n2[KEY_BITS-1:0];
        end else if (unit_t >= unit_n1) begin
            unit_res = unit_t[KEY_BITS-1:0] - n_k;
        end else begin
            unit_res = unit_t[KEY_BITS-1:0];
        end
    end

    // sequencer flags
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign mul_last  = (step_cnt_reg == '0);
    assign pow_last  = (bit_cnt_reg == '0);
    assign sq_done   = (state_reg == ST_SQUARE) && mul_last;
    assign take_mult = sq_done && exp_reg[KEY_BITS-1];
    assign bit_done  = (sq_done && !exp_reg[KEY_BITS-1]) || ((state_reg == ST_MULT) && mul_last);
    assign pow_done  = bit_done && pow_last;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = small_n ? ST_WRITE : ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                if (mul_last) begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                priority if (take_mult) begin
                    state_next = ST_MULT;
                end else if (pow_done && verify_reg) begin
                    state_next = ST_WRITE;
                end else begin
                    state_next = ST_SQUARE;
                end
            end
            ST_MULT: begin
                if (mul_last) begin
                    state_next = (pow_done && verify_reg) ? ST_WRITE : ST_SQUARE;
                end
            end
            ST_WRITE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        s_ready = (state_reg == ST_IDLE);
        m_valid = m_valid_reg;
    end

    assign m_signature   = m_signature_reg;
    assign m_recovered   = m_recovered_reg;
    assign m_matches_res = m_matches_res_reg;

    // datapath
    always_comb begin
        rem_next           = rem_reg;
        h_next             = h_reg;
        base_next          = base_reg;
        exp_next           = exp_reg;
        pacc_next          = pacc_reg;
        macc_next          = macc_reg;
        mop_next           = mop_reg;
        sig_next           = sig_reg;
        rec_next           = rec_reg;
        step_cnt_next      = step_cnt_reg;
        bit_cnt_next       = bit_cnt_reg;
        verify_next        = verify_reg;
        m_signature_next   = m_signature_reg;
        m_recovered_next   = m_recovered_reg;
        m_matches_res_next = m_matches_res_reg;
        m_valid_next       = m_valid_reg && !m_ready;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    h_next        = h_k;
                    rem_next      = '0;
                    sig_next      = '0;
                    rec_next      = '0;
                    step_cnt_next = CNT_MAX;
                    verify_next   = 1'b0;
                end
            end
            ST_REDUCE: begin
                rem_next      = unit_res;
                h_next        = h_reg << 1;
                step_cnt_next = step_cnt_reg - 1'b1;
                if (mul_last) begin
                    base_next     = unit_res;
                    exp_next      = d_k;
                    pacc_next     = KEY_ONE;
                    mop_next      = KEY_ONE;
                    macc_next     = '0;
                    step_cnt_next = CNT_MAX;
                    bit_cnt_next  = CNT_MAX;
                end
            end
            ST_SQUARE, ST_MULT: begin
                macc_next     = unit_res;
                mop_next      = mop_reg << 1;
                step_cnt_next = step_cnt_reg - 1'b1;
                if (mul_last) begin
                    pacc_next     = unit_res;
                    macc_next     = '0;
                    step_cnt_next = CNT_MAX;
                    if (take_mult) begin
                        mop_next = base_reg;
                    end else begin
                        exp_next     = exp_reg << 1;
                        bit_cnt_next = bit_cnt_reg - 1'b1;
                        mop_next     = unit_res;
                        if (pow_last) begin
                            if (!verify_reg) begin
                                sig_next     = unit_res;
                                base_next    = unit_res;
                                exp_next     = e_k;
                                pacc_next    = KEY_ONE;
                                mop_next     = KEY_ONE;
                                bit_cnt_next = CNT_MAX;
                                verify_next  = 1'b1;
                            end else begin
                                rec_next = unit_res;
                            end
                        end
                    end
                end
            end
            ST_WRITE: begin
                if (out_free) begin
                    m_signature_next   = sig_wide[FIELD_W-1:0];
                    m_recovered_next   = rec_wide[FIELD_W-1:0];
                    m_matches_res_next = (rec_reg == rem_reg);
                    m_valid_next       = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg  <= 32'd21;
            priv_exp_reg <= 32'd5;
            pub_exp_reg  <= 32'd5;
            state_reg    <= ST_IDLE;
            step_cnt_reg <= '0;
            bit_cnt_reg  <= '0;
            verify_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            modulus_reg  <= modulus_next;
            priv_exp_reg <= priv_exp_next;
            pub_exp_reg  <= pub_exp_next;
            state_reg    <= state_next;
            step_cnt_reg <= step_cnt_next;
            bit_cnt_reg  <= bit_cnt_next;
            verify_reg   <= verify_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg           <= rem_next;
        h_reg             <= h_next;
        base_reg          <= base_next;
        exp_reg           <= exp_next;
        pacc_reg          <= pacc_next;
        macc_reg          <= macc_next;
        mop_reg           <= mop_next;
        sig_reg           <= sig_next;
        rec_reg           <= rec_next;
        m_signature_reg   <= m_signature_next;
        m_recovered_reg   <= m_recovered_next;
        m_matches_res_reg <= m_matches_res_next;
    end

    // assertions
    `ASSERT_NEXT(a_write_fills_output, aclk, aresetn, (state_reg == ST_WRITE) && out_free, m_valid_reg, "finished item not moved to output register")
    `ASSERT_SAME(a_macc_reduced, aclk, aresetn, (state_reg == ST_SQUARE) || (state_reg == ST_MULT), macc_reg < n_k, "product accumulator not below modulus")
    `ASSERT_SAME(a_pacc_reduced, aclk, aresetn, (state_reg == ST_SQUARE) || (state_reg == ST_MULT), pacc_reg < n_k, "power accumulator not below modulus")
    `ASSERT_SAME(a_rem_reduced, aclk, aresetn, state_reg == ST_REDUCE, rem_reg < n_k, "remainder not below modulus")

endmodule

`default_nettype wire

// ----- test/rsa_sign_and_verify_tb.sv -----
`timescale 1ns / 1ps

module rsa_sign_and_verify_tb
    import rsasv_pkg::*;
();

    localparam int unsigned LIMIT_CYCLES = 3_000_000;
    localparam int unsigned RX_STALL_MAX = 40;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES  = 15_000;
    localparam logic [1:0]  REG_SPARE    = 2'd3;

    typedef struct packed {
        logic [FIELD_W-1:0] signature;
        logic [FIELD_W-1:0] recovered;
        logic               matches_res;
    } rsa_result_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_valid;
    logic                  s_ready;
    logic [FIELD_W-1:0]    s_message_hash;
    logic                  m_valid;
    logic                  m_ready;
    logic [FIELD_W-1:0]    m_signature;
    logic [FIELD_W-1:0]    m_recovered;
    logic                  m_matches_res;

    logic [31:0] key_modulus;
    logic [31:0] key_private;
    logic [31:0] key_public;

    rsa_result_t pending_results[$];
    rsa_result_t want_result;
    int          error_count;
    int unsigned cycle_count;

    int unsigned rx_hold;
    bit          rx_stalls_on;
    bit          rx_busy;
    int unsigned rx_left;

    rsa_sign_and_verify i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_message_hash(s_message_hash),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_signature   (m_signature),
        .m_recovered   (m_recovered),
        .m_matches_res (m_matches_res)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // exact (a * b) mod n, a and b below n
    function automatic logic [63:0] modmul(input logic [63:0] a, input logic [63:0] b,
                                           input logic [63:0] n);
        return (a * b) % n;
    endfunction

    // square-and-multiply from the top exponent bit
    function automatic logic [63:0] modpow(input logic [63:0] base, input logic [31:0] ex,
                                           input logic [63:0] n);
        logic [63:0] acc;
        acc = 64'd1;
        for (int i = 31; i >= 0; i--) begin
            acc = modmul(acc, acc, n);
            if (ex[i]) begin
                acc = modmul(acc, base, n);
            end
        end
        return acc;
    endfunction

    function automatic rsa_result_t sign_and_check(input logic [FIELD_W-1:0] hash);
        logic [63:0] n;
        logic [63:0] reduced;
        logic [63:0] sig;
        logic [63:0] rec;
        rsa_result_t r;
        n = {32'd0, key_modulus};
        if (n < 2) begin
            reduced = 64'd0;
            sig = 64'd0;
            rec = 64'd0;
        end else begin
            reduced = {32'd0, hash} % n;
            sig = modpow(reduced, key_private, n);
            rec = modpow(sig, key_public, n);
        end
        r.signature   = sig[31:0];
        r.recovered   = rec[31:0];
        r.matches_res = (rec == reduced);
        return r;
    endfunction

    // returns 0 when a has no inverse mod m
    function automatic longint mod_inverse(input longint a, input longint m);
        longint r0;
        longint r1;
        longint t0;
        longint t1;
        longint q;
        longint tmp;
        r0 = m;
        r1 = a % m;
        t0 = 0;
        t1 = 1;
        while (r1 != 0) begin
            q = r0 / r1;
            tmp = r0 - q * r1;
            r0 = r1;
            r1 = tmp;
            tmp = t0 - q * t1;
            t0 = t1;
            t1 = tmp;
        end
        if (r0 != 1) begin
            return 0;
        end
        if (t0 < 0) begin
            t0 += m;
        end
        return t0;
    endfunction

    // result side: ready and stall stretches, plus a long hold on request
    initial begin
        m_ready = 1'b0;
        rx_left = 0;
        rx_busy = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold > 0) begin
                rx_hold--;
                m_ready <= 1'b0;
            end else begin
                if (rx_left == 0) begin
                    rx_busy = rx_stalls_on && ($urandom_range(0, 2) == 0);
                    rx_left = rx_busy ? $urandom_range(1, RX_STALL_MAX) : $urandom_range(1, 60);
                end
                rx_left--;
                m_ready <= !rx_busy;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: signature %h recovered %h", m_signature, m_recovered);
                error_count++;
            end else begin
                want_result = pending_results.pop_front();
                if (m_signature !== want_result.signature) begin
                    $error("signature: expected %h, got %h", want_result.signature, m_signature);
                    error_count++;
                end
                if (m_recovered !== want_result.recovered) begin
                    $error("recovered: expected %h, got %h", want_result.recovered, m_recovered);
                    error_count++;
                end
                if (m_matches_res !== want_result.matches_res) begin
                    $error("matches_res: expected %b, got %b", want_result.matches_res,
                           m_matches_res);
                    error_count++;
                end
            end
        end
    end

    task automatic send_hash(input logic [FIELD_W-1:0] hash);
        @(negedge aclk);
        s_message_hash <= hash;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(sign_and_check(hash));
    endtask

    task automatic pause_sender(input int unsigned n);
        @(negedge aclk);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic send_hash_stream(input int unsigned count);
        int unsigned left;
        int unsigned burst;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 6);
            if (burst > left) begin
                burst = left;
            end
            repeat (burst) send_hash($urandom);
            left -= burst;
            if ($urandom_range(0, 7) == 0) begin
                pause_sender($urandom_range(1000, 4500));
            end else if ($urandom_range(0, 3) != 0) begin
                pause_sender($urandom_range(1, 40));
            end
        end
        pause_sender(1);
    endtask

    task automatic apb_access(input logic wr, input logic [1:0] index,
                              input logic [CFG_DATA_W-1:0] wdata,
                              output logic [CFG_DATA_W-1:0] rdata);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {index, 2'b00};
        pwdata <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_register(input logic [1:0] index, input logic [31:0] value);
        logic [CFG_DATA_W-1:0] rdata;
        apb_access(1'b1, index, value, rdata);
        case (index)
            REG_MODULUS:  key_modulus = value;
            REG_PRIV_EXP: key_private = value;
            REG_PUB_EXP:  key_public = value;
            default: ;
        endcase
        if (index != REG_SPARE) begin
            apb_access(1'b0, index, '0, rdata);
            if (rdata !== value) begin
                $error("prdata of register %0d: expected %h, got %h", index, value, rdata);
                error_count++;
            end
        end
    endtask

    task automatic load_key(input logic [31:0] n, input logic [31:0] d, input logic [31:0] e);
        write_register(REG_MODULUS, n);
        write_register(REG_PRIV_EXP, d);
        write_register(REG_PUB_EXP, e);
    endtask

    task automatic test_reset_key();
        send_hash(32'd0);
        send_hash(32'd1);
        send_hash(32'd20);
        send_hash(32'd21);
        send_hash(32'hFFFF_FFFF);
        send_hash(32'h8000_0000);
        pause_sender(1);
        wait_drained();
    endtask

    task automatic test_register_map();
        write_register(REG_SPARE, 32'h0000_0003);
        send_hash(32'h1234_5678);
        pause_sender(3);
        send_hash(32'hEDCB_A987);
        pause_sender(1);
        wait_drained();
    endtask

    task automatic test_small_modulus();
        load_key(32'd0, 32'd7, 32'd3);
        send_hash(32'hFFFF_FFFF);
        send_hash(32'd5);
        pause_sender(1);
        wait_drained();
        write_register(REG_MODULUS, 32'd1);
        send_hash(32'd0);
        send_hash(32'd7);
        pause_sender(1);
        wait_drained();
        write_register(REG_MODULUS, 32'd2);
        send_hash(32'hFFFF_FFFF);
        send_hash(32'hFFFF_FFFE);
        pause_sender(1);
        wait_drained();
    endtask

    task automatic test_exponent_extremes();
        load_key(32'hFFFF_FFFF, 32'd0, 32'd0);
        send_hash(32'd0);
        send_hash(32'hFFFF_FFFF);
        send_hash(32'hFFFF_FFFE);
        pause_sender(1);
        wait_drained();
        load_key(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_hash(32'h1234_5678);
        send_hash(32'hFFFF_FFFE);
        send_hash(32'd1);
        pause_sender(1);
        wait_drained();
        load_key(32'hFFFF_FFFB, 32'hFFFF_FFFF, 32'd1);
        send_hash(32'd0);
        send_hash(32'hFFFF_FFFA);
        send_hash(32'hAAAA_5555);
        pause_sender(1);
        wait_drained();
    endtask

    task automatic test_textbook_key();
        load_key(32'd3233, 32'(mod_inverse(17, 3120)), 32'd17);
        rx_stalls_on = 1'b1;
        send_hash_stream(14);
        wait_drained();
    endtask

    task automatic test_random_keys();
        longint p;
        longint q;
        longint phi;
        longint e;
        longint d;
        for (int phase = 0; phase < 6; phase++) begin
            case ($urandom_range(0, 3))
                0: begin p = 61; q = 53; end
                1: begin p = 251; q = 241; end
                2: begin p = 65519; q = 65521; end
                default: begin p = 65521; q = 65537; end
            endcase
            phi = (p - 1) * (q - 1);
            do begin
                e = longint'($urandom | 32'd1);
                d = mod_inverse(e, phi);
            end while (d == 0);
            if (phase == 5) begin
                load_key($urandom_range(2, 32'hFFFF_FFFF), $urandom, $urandom);
            end else begin
                load_key(32'(p * q), 32'(d), 32'(e));
            end
            rx_stalls_on = (phase != 2);
            send_hash_stream(16);
            wait_drained();
        end
    endtask

    task automatic test_backpressure();
        rx_stalls_on = 1'b0;
        @(posedge aclk);
        rx_hold = HOLD_CYCLES;
        repeat (6) send_hash($urandom);
        pause_sender(1);
        wait_drained();
    endtask

    initial begin
        aresetn = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_valid = 1'b0;
        s_message_hash = '0;
        rx_hold = 0;
        rx_stalls_on = 1'b0;
        error_count = 0;
        cycle_count = 0;
        key_modulus = 32'd21;
        key_private = 32'd5;
        key_public = 32'd5;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_key();
        test_register_map();
        test_small_modulus();
        test_exponent_extremes();
        test_textbook_key();
        test_random_keys();
        test_backpressure();

        wait_drained();
        repeat (50) @(posedge aclk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
